// File: rtl/ultrasonic_range_finder_core_assert.svh
// assertion macros shared by the ultrasonic range finder rtl
// no dependencies; included by the modules that carry assertions
`ifndef ULTRASONIC_RANGE_FINDER_CORE_ASSERT_SVH
`define ULTRASONIC_RANGE_FINDER_CORE_ASSERT_SVH

// condition must hold on every clock edge out of reset
`define URF_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("urf assertion failed");

// consequent must hold on the same edge as the antecedent
`define URF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urf assertion failed");

`endif

// File: rtl/urf_pkg.sv
// shared types and constants for the ultrasonic range finder
// no dependencies
package urf_pkg;

    localparam int COUNT_W = 20;
    localparam int SINCE_W = 24;
    localparam int DIST_W  = 17;
    localparam int TMO_W   = 16;
    localparam int THR_W   = 17;
    localparam int BUZZ_W  = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUZZ     = 4'd3;

    // reset values of the registers
    localparam logic [SINCE_W-1:0] INTERVAL_RST = 24'd100000;
    localparam logic [THR_W-1:0]   THRESH_RST   = 17'd2000;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST  = 16'd30000;
    localparam logic [BUZZ_W-1:0]  BUZZ_RST     = 20'd200000;

    localparam logic [COUNT_W-1:0] LOW_TICKS  = 20'd2;
    localparam logic [COUNT_W-1:0] HIGH_TICKS = 20'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 20'hFFFFF;
    localparam logic [COUNT_W-1:0] WIDTH_MAX  = 20'h0FFFF;
    localparam logic [SINCE_W-1:0] SINCE_MAX  = 24'hFFFFFF;

    // 50/29 = 1 remainder 21, stepped once per echo tick
    localparam logic [5:0] DIV_STEP_REM = 6'd21;
    localparam logic [5:0] DIV_DIVISOR  = 6'd29;

    typedef struct packed {
        logic [SINCE_W-1:0] interval_us;
        logic [THR_W-1:0]   threshold_hcm;
        logic [TMO_W-1:0]   echo_timeout_us;
        logic [BUZZ_W-1:0]  buzz_us;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic advance;
    } dist_cmd_t;

    typedef struct packed {
        logic              trigger_level;
        logic              buzzer_level;
        logic              measure_done;
        logic              timed_out;
        logic [DIST_W-1:0] distance_hcm;
        logic              too_close;
    } result_t;

endpackage

// File: rtl/urf_dist.sv
// running distance tracker: floor(50*width/29) kept as quotient and remainder
// depends on urf_pkg
module urf_dist
    import urf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dist_cmd_t         cmd,
    output logic [DIST_W-1:0] dist_hcm
);

    logic [DIST_W-1:0] quot_reg, quot_next;
    logic [4:0]        rem_reg, rem_next;
    logic [5:0]        rem_sum;

    assign rem_sum = {1'b0, rem_reg} + DIV_STEP_REM;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (cmd.clear)
        begin
            quot_next = '0;
            rem_next  = '0;
        end
        else if (cmd.advance)
        begin
            if (rem_sum >= DIV_DIVISOR)
            begin
                rem_next  = 5'(rem_sum - DIV_DIVISOR);
                quot_next = quot_reg + DIST_W'(2);
            end
            else
            begin
                rem_next  = rem_sum[4:0];
                quot_next = quot_reg + DIST_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign dist_hcm = quot_reg;

endmodule

// File: rtl/urf_ctrl.sv
// measurement sequencer: trigger pulse, echo timing, buzzer hold-off
// depends on urf_pkg; drives urf_dist through a command struct
module urf_ctrl
    import urf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              echo_level,
    input  cfg_t              cfg,
    input  logic [DIST_W-1:0] dist_hcm,
    output dist_cmd_t         dist_cmd,
    output result_t           result
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4,
        PH_BUZZ      = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic [SINCE_W-1:0] since_reg, since_next, since_inc;
    logic [COUNT_W-1:0] timeout_ext;
    dist_cmd_t          cmd;

    assign count_inc   = (count_reg != COUNT_MAX) ? count_reg + COUNT_W'(1) : count_reg;
    assign since_inc   = (since_reg != SINCE_MAX) ? since_reg + SINCE_W'(1) : since_reg;
    assign timeout_ext = COUNT_W'(cfg.echo_timeout_us);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        since_next = since_inc;
        cmd        = '0;
        result     = '0;
        unique case (phase_reg)
            PH_TRIG_LOW:
            begin
                count_next = count_inc;
                if (count_inc >= LOW_TICKS)
                begin
                    phase_next = PH_TRIG_HIGH;
                    count_next = '0;
                end
            end
            PH_TRIG_HIGH:
            begin
                result.trigger_level = 1'b1;
                count_next = count_inc;
                if (count_inc >= HIGH_TICKS)
                begin
                    phase_next = PH_WAIT_RISE;
                    count_next = '0;
                end
            end
            PH_WAIT_RISE:
            begin
                if (echo_level)
                begin
                    phase_next = PH_MEASURE;
                    count_next = '0;
                    cmd.clear  = 1'b1;
                end
                else if (count_reg > timeout_ext)
                begin
                    result.measure_done = 1'b1;
                    result.timed_out    = 1'b1;
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_MEASURE:
            begin
                if (!echo_level)
                begin
                    // tracker already holds the distance of the saturated width
                    result.measure_done = 1'b1;
                    result.distance_hcm = dist_hcm;
                    result.too_close    = (dist_hcm < cfg.threshold_hcm);
                    phase_next = (dist_hcm < cfg.threshold_hcm) ? PH_BUZZ : PH_IDLE;
                    count_next = '0;
                end
                else if (count_reg > timeout_ext)
                begin
                    result.measure_done = 1'b1;
                    result.timed_out    = 1'b1;
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else
                begin
                    count_next  = count_inc;
                    cmd.advance = (count_reg < WIDTH_MAX);
                end
            end
            PH_BUZZ:
            begin
                result.buzzer_level = 1'b1;
                count_next = count_inc;
                if (count_inc >= COUNT_W'(cfg.buzz_us))
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            default:
            begin
                // idle and unused codes
                phase_next = PH_IDLE;
                count_next = '0;
                if (since_inc > cfg.interval_us)
                begin
                    since_next = '0;
                    phase_next = PH_TRIG_LOW;
                    count_next = COUNT_W'(1);
                end
            end
        endcase
    end

    assign dist_cmd.clear   = accept & cmd.clear;
    assign dist_cmd.advance = accept & cmd.advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            since_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            since_reg <= since_next;
        end
    end

endmodule

// File: rtl/urf_out_stage.sv
// result register between the sequencer and the output channel
// depends on urf_pkg
module urf_out_stage
    import urf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_next,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    in_stall,
    output result_t result_reg
);

    logic valid_reg, valid_next;

    // a new transfer may enter when the register is empty or draining
    assign in_stall = valid_reg & out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    assign out_valid = valid_reg;

endmodule

// File: rtl/ultrasonic_range_finder_core.sv
// top level of the ultrasonic range finder: config registers and channel glue
// depends on urf_pkg, urf_dist, urf_ctrl, urf_out_stage and the assertion macros
`include "ultrasonic_range_finder_core_assert.svh"

// usage
//   input channel: one transfer per microsecond tick, carrying echo_level
//   output channel: exactly one result transfer per input transfer, in order
//   config port: cfg_we/cfg_index/cfg_wdata, written only while no result is
//   pending; index 0 interval, 1 threshold, 2 echo timeout, 3 buzz time,
//   other indexes are ignored
// result timing: the result of a tick is in the output register on the edge that
//   takes the tick, so out_valid rises in the cycle after the input transfer
// throughput: one tick per cycle while out_stall is low; the single output register
//   can reload on the same edge it is drained, so back-to-back ticks flow without bubbles
// stall: while out_stall holds a full output register, in_stall is raised and
//   no tick is taken; the sequencer state does not move until it drains
// reset: registers return to their defaults (100000, 2000, 30000, 200000),
//   the sequencer goes idle with all counters at zero, output is empty
// distance is tracked while the echo is high as quotient and remainder of
//   50*width/29, so no divider sits in the result path
module ultrasonic_range_finder_core
    import urf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  echo_level,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  trigger_level,
    output logic                  buzzer_level,
    output logic                  measure_done,
    output logic                  timed_out,
    output logic [DIST_W-1:0]     distance_hcm,
    output logic                  too_close
);

    cfg_t              cfg_reg;
    logic              accept;
    dist_cmd_t         dist_cmd;
    logic [DIST_W-1:0] dist_hcm;
    result_t           result_next;
    result_t           result_reg;

    // input transfer
    assign accept = in_valid & ~in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval_us     <= INTERVAL_RST;
            cfg_reg.threshold_hcm   <= THRESH_RST;
            cfg_reg.echo_timeout_us <= TIMEOUT_RST;
            cfg_reg.buzz_us         <= BUZZ_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INTERVAL: cfg_reg.interval_us     <= cfg_wdata[SINCE_W-1:0];
                REG_THRESH:   cfg_reg.threshold_hcm   <= cfg_wdata[THR_W-1:0];
                REG_TIMEOUT:  cfg_reg.echo_timeout_us <= cfg_wdata[TMO_W-1:0];
                REG_BUZZ:     cfg_reg.buzz_us         <= cfg_wdata[BUZZ_W-1:0];
                default:      ;
            endcase
        end
    end

    // running distance of the echo under way
    urf_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dist_cmd),
        .dist_hcm (dist_hcm)
    );

    // phase sequencer, one step per accepted tick
    urf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .echo_level (echo_level),
        .cfg        (cfg_reg),
        .dist_hcm   (dist_hcm),
        .dist_cmd   (dist_cmd),
        .result     (result_next)
    );

    // result register and output handshake
    urf_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .result_next (result_next),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .in_stall    (in_stall),
        .result_reg  (result_reg)
    );

    assign trigger_level = result_reg.trigger_level;
    assign buzzer_level  = result_reg.buzzer_level;
    assign measure_done  = result_reg.measure_done;
    assign timed_out     = result_reg.timed_out;
    assign distance_hcm  = result_reg.distance_hcm;
    assign too_close     = result_reg.too_close;

    // a timeout result carries no distance and no proximity flag
    `URF_ASSERT_IMPLIES(a_tmo_clean, clk, rst_n, out_valid && timed_out, measure_done && distance_hcm == '0 && !too_close)
    // proximity is only reported on a finished, valid measurement
    `URF_ASSERT_IMPLIES(a_close_done, clk, rst_n, out_valid && too_close, measure_done && !timed_out)
    // trigger pulse and buzzer never overlap
    `URF_ASSERT_HOLDS(a_trig_buzz, clk, rst_n, !(out_valid && trigger_level && buzzer_level))
    // input is only held off by a full, stalled result register
    `URF_ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

// File: sim/ultrasonic_range_finder_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench for ultrasonic_range_finder_core: directed, pressure and random ticks
// depends on urf_pkg and the ultrasonic_range_finder_core rtl; needs nothing else
module ultrasonic_range_finder_core_test;
    import urf_pkg::*;

    // sequencer phases as the predictor tracks them
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_TRIG_LOW,
        SEQ_TRIG_HIGH,
        SEQ_WAIT_RISE,
        SEQ_MEASURE,
        SEQ_BUZZ
    } seq_phase_t;

    // distance scaling: width * 50 / 29 hundredths of a cm
    localparam int unsigned DIST_MUL = 50;
    localparam int unsigned DIST_DIV = 29;

    localparam logic [CFG_IDX_W-1:0] IDX_LAST    = {CFG_IDX_W{1'b1}};
    localparam logic [THR_W-1:0]     THR_ALL     = {THR_W{1'b1}};
    localparam logic [TMO_W-1:0]     TIMEOUT_MAX = {TMO_W{1'b1}};

    localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer before giving up
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off in the pressure test
    localparam int MAX_GAP       = 8;     // longest sender gap between ticks
    localparam int SETTLE_CYCLES = 3;     // quiet cycles before a register write or the end
    localparam int STRAY_PCT     = 6;     // stray echo highs outside a measurement
    localparam int PLAN_SPAN     = 60;    // cap on planned echo delay and width
    localparam int RANDOM_ITEMS  = 200;   // random ticks per idling mode
    localparam int SEGMENTS      = 5;     // register settings per idling mode

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
    logic                  in_valid   = 1'b0;
    logic                  echo_level = 1'b0;
    logic                  out_stall  = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    logic                  trigger_level;
    logic                  buzzer_level;
    logic                  measure_done;
    logic                  timed_out;
    logic [DIST_W-1:0]     distance_hcm;
    logic                  too_close;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    ultrasonic_range_finder_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .echo_level    (echo_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .trigger_level (trigger_level),
        .buzzer_level  (buzzer_level),
        .measure_done  (measure_done),
        .timed_out     (timed_out),
        .distance_hcm  (distance_hcm),
        .too_close     (too_close)
    );

    // ------------------------------------------------------------------
    // shared state of the bench
    // ------------------------------------------------------------------
    result_t     pending_results[$];   // predicted tick results not yet seen
    result_t     seen_result;          // output payload sampled before the edge
    result_t     oldest_result;
    bit          in_take;              // input transfer happens on the coming edge
    bit          out_take;             // output transfer happens on the coming edge
    int unsigned error_count   = 0;
    int unsigned result_count  = 0;
    int unsigned quiet_cycles  = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_cycles = 0;

    // echo plan for the measurement in progress
    int unsigned plan_rise  = 0;
    int unsigned plan_width = 0;
    bit          plan_noisy = 1'b0;

    // predictor state, mirrors the block after every accepted tick
    cfg_t               ranger_cfg = '{INTERVAL_RST, THRESH_RST, TIMEOUT_RST, BUZZ_RST};
    seq_phase_t         seq_phase  = SEQ_IDLE;
    logic [COUNT_W-1:0] seq_count  = '0;
    logic [SINCE_W-1:0] ticks_since_start = '0;

    // ------------------------------------------------------------------
    // sampling: nothing moves between the falling edge and the next rising
    // edge, so values taken here are the ones the rising edge will see
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        in_take     = (in_valid === 1'b1) && (in_stall === 1'b0);
        out_take    = (out_valid === 1'b1) && (out_stall === 1'b0);
        seen_result = {trigger_level, buzzer_level, measure_done, timed_out,
                       distance_hcm, too_close};
    end

    task automatic report_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got !== want)
            report_error($sformatf("result %0d field %s: got %0d, expected %0d",
                                   result_count, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // result checker: every output transfer is matched against the oldest
    // prediction, field by field
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (out_take)
        begin
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("result transfer %0d with nothing pending",
                                       result_count));
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("trigger_level", seen_result.trigger_level,
                            oldest_result.trigger_level);
                check_field("buzzer_level", seen_result.buzzer_level,
                            oldest_result.buzzer_level);
                check_field("measure_done", seen_result.measure_done,
                            oldest_result.measure_done);
                check_field("timed_out", seen_result.timed_out, oldest_result.timed_out);
                check_field("distance_hcm", seen_result.distance_hcm,
                            oldest_result.distance_hcm);
                check_field("too_close", seen_result.too_close, oldest_result.too_close);
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, or a long hold-off when one is requested
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog: a run that stops moving ends as a failure
    always @(posedge clk)
    begin
        if (in_take || out_take)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tick predictor
    // ------------------------------------------------------------------
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v != COUNT_MAX) ? v + 1'b1 : v;
    endfunction

    // advances the predicted sequencer by one tick and returns its outputs
    task automatic ranging_step(input logic echo, output result_t r);
        logic [COUNT_W-1:0] width_ticks;
        logic [31:0]        dist_val;
        r = '0;
        if (ticks_since_start != SINCE_MAX)
            ticks_since_start++;
        case (seq_phase)
            SEQ_TRIG_LOW:
            begin
                seq_count = sat_inc(seq_count);
                if (seq_count >= LOW_TICKS)
                begin
                    seq_phase = SEQ_TRIG_HIGH;
                    seq_count = '0;
                end
            end
            SEQ_TRIG_HIGH:
            begin
                r.trigger_level = 1'b1;
                seq_count = sat_inc(seq_count);
                if (seq_count >= HIGH_TICKS)
                begin
                    seq_phase = SEQ_WAIT_RISE;
                    seq_count = '0;
                end
            end
            SEQ_WAIT_RISE:
            begin
                if (echo)
                begin
                    seq_phase = SEQ_MEASURE;
                    seq_count = '0;
                end
                else if (seq_count > ranger_cfg.echo_timeout_us)
                begin
                    r.measure_done = 1'b1;
                    r.timed_out    = 1'b1;
                    seq_phase      = SEQ_IDLE;
                    seq_count      = '0;
                end
                else
                begin
                    seq_count = sat_inc(seq_count);
                end
            end
            SEQ_MEASURE:
            begin
                if (!echo)
                begin
                    width_ticks = (seq_count > WIDTH_MAX) ? WIDTH_MAX : seq_count;
                    dist_val = (32'(width_ticks) * DIST_MUL) / DIST_DIV;
                    r.measure_done = 1'b1;
                    r.distance_hcm = dist_val[DIST_W-1:0];
                    seq_count      = '0;
                    if (dist_val < ranger_cfg.threshold_hcm)
                    begin
                        r.too_close = 1'b1;
                        seq_phase   = SEQ_BUZZ;
                    end
                    else
                    begin
                        seq_phase = SEQ_IDLE;
                    end
                end
                else if (seq_count > ranger_cfg.echo_timeout_us)
                begin
                    r.measure_done = 1'b1;
                    r.timed_out    = 1'b1;
                    seq_phase      = SEQ_IDLE;
                    seq_count      = '0;
                end
                else
                begin
                    seq_count = sat_inc(seq_count);
                end
            end
            SEQ_BUZZ:
            begin
                r.buzzer_level = 1'b1;
                seq_count = sat_inc(seq_count);
                if (seq_count >= ranger_cfg.buzz_us)
                begin
                    seq_phase = SEQ_IDLE;
                    seq_count = '0;
                end
            end
            default:
            begin
                seq_phase = SEQ_IDLE;
                seq_count = '0;
                if (ticks_since_start > ranger_cfg.interval_us)
                begin
                    ticks_since_start = '0;
                    seq_phase         = SEQ_TRIG_LOW;
                    seq_count         = COUNT_W'(1);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one tick transfer; a random gap may come first, then valid stays up
    // with a steady payload until the block takes it
    task automatic send_tick(input logic echo, output result_t predicted);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        echo_level <= echo;
        do @(posedge clk); while (!in_take);
        ranging_step(echo, predicted);
        pending_results.push_back(predicted);
    endtask

    // sender pauses until every predicted result has been seen
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only with no result pending; the predictor follows
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INTERVAL: ranger_cfg.interval_us     = data[SINCE_W-1:0];
            REG_THRESH:   ranger_cfg.threshold_hcm   = data[THR_W-1:0];
            REG_TIMEOUT:  ranger_cfg.echo_timeout_us = data[TMO_W-1:0];
            REG_BUZZ:     ranger_cfg.buzz_us         = data[BUZZ_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic write_all(input logic [SINCE_W-1:0] interval, input logic [THR_W-1:0] thr,
                             input logic [TMO_W-1:0] tmo, input logic [BUZZ_W-1:0] buzz);
        write_reg(REG_INTERVAL, CFG_DATA_W'(interval));
        write_reg(REG_THRESH, CFG_DATA_W'(thr));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
        write_reg(REG_BUZZ, CFG_DATA_W'(buzz));
    endtask

    // echo level for the next tick, following the plan of the measurement
    function automatic logic next_echo();
        if (plan_noisy && (seq_phase == SEQ_WAIT_RISE || seq_phase == SEQ_MEASURE))
            return 1'($urandom_range(1));
        case (seq_phase)
            SEQ_WAIT_RISE: return (seq_count >= plan_rise);
            SEQ_MEASURE:   return (seq_count < plan_width);
            default:       return ($urandom_range(99) < STRAY_PCT);
        endcase
    endfunction

    // mostly clean echoes inside the timeout, some that overrun it, some noise
    task automatic choose_plan();
        int unsigned lim;
        lim = (ranger_cfg.echo_timeout_us > PLAN_SPAN) ? PLAN_SPAN
                                                       : ranger_cfg.echo_timeout_us;
        if ($urandom_range(99) >= 80)
            lim = lim + 2;
        plan_noisy = ($urandom_range(99) < 10);
        plan_rise  = $urandom_range(0, lim);
        plan_width = $urandom_range(0, lim);
    endtask

    // runs ticks until one measurement has finished and the buzzer is done
    task automatic measure_once(input int unsigned rise, input int unsigned width);
        result_t     r;
        bit          finished;
        int unsigned guard;
        plan_rise  = rise;
        plan_width = width;
        plan_noisy = 1'b0;
        finished   = 1'b0;
        guard      = 0;
        while (!(finished && seq_phase == SEQ_IDLE) && guard < 200000)
        begin
            send_tick(next_echo(), r);
            if (r.measure_done)
                finished = 1'b1;
            guard++;
        end
        if (!finished)
            report_error("measurement never completed");
    endtask

    // register data with random junk above the register width
    function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned v, input int w);
        logic [31:0] raw;
        raw = $urandom;
        if (w >= CFG_DATA_W)
            return CFG_DATA_W'(v);
        return (raw[CFG_DATA_W-1:0] << w) | CFG_DATA_W'(v);
    endfunction

    task automatic randomize_config();
        int unsigned pick;
        logic [31:0] raw;
        raw  = $urandom;
        pick = $urandom_range(99);
        if (pick < 70)
            write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(0, 30)));
        else if (pick < 90)
            write_reg(REG_INTERVAL, CFG_DATA_W'($urandom_range(31, 400)));
        else
            write_reg(REG_INTERVAL, raw[SINCE_W-1:0]);
        pick = $urandom_range(99);
        if (pick < 40)
            write_reg(REG_THRESH, with_junk($urandom_range(0, 80), THR_W));
        else if (pick < 60)
            write_reg(REG_THRESH, with_junk(0, THR_W));
        else
            write_reg(REG_THRESH, with_junk($urandom_range(0, THR_ALL), THR_W));
        pick = $urandom_range(99);
        if (pick < 80)
            write_reg(REG_TIMEOUT, with_junk($urandom_range(0, 40), TMO_W));
        else if (pick < 95)
            write_reg(REG_TIMEOUT, with_junk($urandom_range(41, 150), TMO_W));
        else
            write_reg(REG_TIMEOUT, with_junk($urandom_range(0, TIMEOUT_MAX), TMO_W));
        pick = $urandom_range(99);
        if (pick < 85)
            write_reg(REG_BUZZ, with_junk($urandom_range(0, 20), BUZZ_W));
        else
            write_reg(REG_BUZZ, with_junk($urandom_range(0, COUNT_MAX), BUZZ_W));
        // writes past the last register must leave everything as it was
        if ($urandom_range(99) < 30)
            write_reg(CFG_IDX_W'($urandom_range(REG_BUZZ + 1, IDX_LAST)), raw[CFG_DATA_W-1:0]);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset defaults: a start needs more than 100000 ticks, so these stay quiet
    task automatic test_reset_defaults();
        result_t r;
        for (int i = 0; i < 12; i++)
            send_tick(1'(i % 2), r);
    endtask

    // full trigger sequence, clean echoes and both timeouts
    task automatic test_trigger_and_echo();
        write_all('0, THR_ALL, TMO_W'(5), '0);
        measure_once(0, 0);   // rise on the first wait tick, zero width, one buzz tick
        measure_once(2, 3);
        measure_once(7, 0);   // no rise in time
        measure_once(0, 7);   // echo stuck high
    endtask

    // a zero timeout ends a silent wait one tick after it starts
    task automatic test_zero_timeout();
        write_reg(REG_TIMEOUT, '0);
        measure_once(1, 0);
        measure_once(0, 1);
        measure_once(0, 2);
    endtask

    // too-close boundary: width 3 gives 5 hundredths
    task automatic test_threshold_edges();
        write_all('0, THR_W'(5), TMO_W'(10), BUZZ_W'(3));
        measure_once(0, 3);
        write_reg(REG_THRESH, CFG_DATA_W'(6));
        measure_once(1, 3);
        write_reg(REG_THRESH, '0);
        measure_once(0, 0);   // nothing is too close with a zero threshold
        write_reg(IDX_LAST, {CFG_DATA_W{1'b1}});
        measure_once(2, 1);
    endtask

    // an all-ones interval is never exceeded
    task automatic test_huge_interval();
        result_t r;
        write_reg(REG_INTERVAL, SINCE_MAX);
        for (int i = 0; i < 10; i++)
            send_tick(1'($urandom_range(1)), r);
    endtask

    // receiver holds off long enough that the block backs up into the sender
    task automatic test_output_backpressure();
        result_t r;
        write_all('0, THR_W'(40), TMO_W'(20), BUZZ_W'(4));
        hold_off_cycles = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            if (seq_phase == SEQ_IDLE)
                choose_plan();
            send_tick(next_echo(), r);
        end
        drain_results();
    endtask

    task automatic test_random_ranging(input int send_pct, input int recv_pct);
        result_t r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            randomize_config();
            for (int i = 0; i < RANDOM_ITEMS / SEGMENTS; i++)
            begin
                if (seq_phase == SEQ_IDLE)
                    choose_plan();
                send_tick(next_echo(), r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender rarely idles, receiver stalls often
        send_idle_pct = 6;
        recv_idle_pct = 56;
        test_reset_defaults();
        test_trigger_and_echo();
        test_zero_timeout();
        test_threshold_edges();
        test_huge_interval();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_output_backpressure();

        test_random_ranging(6, 56);
        test_random_ranging(56, 6);
        test_random_ranging(0, 0);

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
